// ===== rtl/bbcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bbcs_pkg;

  // Default nesting limit for braces
  localparam int unsigned MAX_DEPTH_DEF = 255;

  // Character codes the scanner reacts to
  localparam logic [7:0] CH_OPEN      = 8'h7B;
  localparam logic [7:0] CH_CLOSE     = 8'h7D;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  // Result codes
  typedef enum logic [2:0] {
    FAIL_NONE       = 3'd0,
    FAIL_EXTRA      = 3'd1,
    FAIL_NO_OPEN    = 3'd2,
    FAIL_UNCLOSED   = 3'd3,
    FAIL_OPEN_STR   = 3'd4,
    FAIL_OPEN_NOTE  = 3'd5,
    FAIL_OVERFLOW   = 3'd6
  } fail_t;

  // One input byte held in the input register
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } item_t;

  // One verdict for a finished text
  typedef struct packed {
    logic  accepted;
    fail_t fail_reason;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/bbcs_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input register: takes a byte whenever empty or being drained this cycle
module bbcs_in_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire bbcs_pkg::item_t in_item,
  output logic                 item_valid,
  input  wire logic            item_take,
  output bbcs_pkg::item_t      item
);

  logic            valid_r, valid_nxt;
  bbcs_pkg::item_t item_r;

  assign in_ready  = !valid_r || item_take;
  assign valid_nxt = in_valid || (valid_r && !item_take);

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, loaded on each transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== rtl/bbcs_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Scanner state and per-byte update; produces a verdict on the last byte
module bbcs_scan #(
  parameter int unsigned MAX_DEPTH = bbcs_pkg::MAX_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            item_valid,
  input  wire bbcs_pkg::item_t item,
  output logic                 item_take,
  input  wire logic            res_ready,
  output logic                 res_valid,
  output bbcs_pkg::result_t    res
);

  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_LIM = DW'(MAX_DEPTH);

  logic [DW-1:0]   depth_r, depth_nxt;
  logic            saw_open_r, saw_open_nxt;
  logic            in_quote_r, in_quote_nxt;
  logic            in_line_r, in_line_nxt;
  logic            in_block_r, in_block_nxt;
  logic            pend_slash_r, pend_slash_nxt;
  logic            pend_star_r, pend_star_nxt;
  logic            prev_bs_r, prev_bs_nxt;
  bbcs_pkg::fail_t fail_r, fail_nxt;

  // Values after this byte, before the end-of-text clear
  logic [DW-1:0]   s_depth;
  logic            s_saw_open, s_in_quote, s_in_line, s_in_block;
  logic            s_pend_slash, s_pend_star, s_done;
  bbcs_pkg::fail_t s_fail;
  bbcs_pkg::fail_t reason;
  logic [7:0]      b;

  assign b         = item.text_byte;
  assign item_take = item_valid && (!item.last_byte || res_ready);
  assign res_valid = item_valid && item.last_byte;

  // Per-byte scan
  always_comb begin
    s_depth      = depth_r;
    s_saw_open   = saw_open_r;
    s_in_quote   = in_quote_r;
    s_in_line    = in_line_r;
    s_in_block   = in_block_r;
    s_pend_slash = pend_slash_r;
    s_pend_star  = pend_star_r;
    s_fail       = fail_r;
    s_done       = 1'b0;
    if (in_line_r) begin
      if (b == bbcs_pkg::CH_NEWLINE) begin
        s_in_line = 1'b0;
      end
    end else if (in_block_r) begin
      if (pend_star_r && b == bbcs_pkg::CH_SLASH) begin
        s_in_block  = 1'b0;
        s_pend_star = 1'b0;
      end else begin
        s_pend_star = (b == bbcs_pkg::CH_STAR);
      end
    end else begin
      // comment opener completes here
      if (pend_slash_r) begin
        s_pend_slash = 1'b0;
        if (b == bbcs_pkg::CH_SLASH) begin
          s_in_line = 1'b1;
          s_done    = 1'b1;
        end else if (b == bbcs_pkg::CH_STAR) begin
          s_in_block  = 1'b1;
          s_pend_star = 1'b0;
          s_done      = 1'b1;
        end
      end
      if (!s_done) begin
        if (!in_quote_r && b == bbcs_pkg::CH_SLASH) begin
          s_pend_slash = 1'b1;
        end else if (b == bbcs_pkg::CH_QUOTE && !prev_bs_r) begin
          s_in_quote = !in_quote_r;
        end else if (!in_quote_r) begin
          if (b == bbcs_pkg::CH_OPEN) begin
            s_saw_open = 1'b1;
            if (depth_r >= DEPTH_LIM) begin
              if (fail_r == bbcs_pkg::FAIL_NONE) s_fail = bbcs_pkg::FAIL_OVERFLOW;
            end else begin
              s_depth = depth_r + 1'b1;
            end
          end else if (b == bbcs_pkg::CH_CLOSE) begin
            if (depth_r == '0) begin
              if (fail_r == bbcs_pkg::FAIL_NONE) s_fail = bbcs_pkg::FAIL_EXTRA;
            end else begin
              s_depth = depth_r - 1'b1;
            end
          end
        end
      end
    end
  end

  // Verdict, first matching reason wins
  always_comb begin
    priority if (s_fail != bbcs_pkg::FAIL_NONE) begin
      reason = s_fail;
    end else if (!s_saw_open) begin
      reason = bbcs_pkg::FAIL_NO_OPEN;
    end else if (s_depth != '0) begin
      reason = bbcs_pkg::FAIL_UNCLOSED;
    end else if (s_in_quote) begin
      reason = bbcs_pkg::FAIL_OPEN_STR;
    end else if (s_in_block) begin
      reason = bbcs_pkg::FAIL_OPEN_NOTE;
    end else begin
      reason = bbcs_pkg::FAIL_NONE;
    end
  end

  assign res.fail_reason = reason;
  assign res.accepted    = (reason == bbcs_pkg::FAIL_NONE);

  // Next state: hold unless a byte is taken; clear after the last byte
  always_comb begin
    depth_nxt      = depth_r;
    saw_open_nxt   = saw_open_r;
    in_quote_nxt   = in_quote_r;
    in_line_nxt    = in_line_r;
    in_block_nxt   = in_block_r;
    pend_slash_nxt = pend_slash_r;
    pend_star_nxt  = pend_star_r;
    prev_bs_nxt    = prev_bs_r;
    fail_nxt       = fail_r;
    if (item_take) begin
      if (item.last_byte) begin
        depth_nxt      = '0;
        saw_open_nxt   = 1'b0;
        in_quote_nxt   = 1'b0;
        in_line_nxt    = 1'b0;
        in_block_nxt   = 1'b0;
        pend_slash_nxt = 1'b0;
        pend_star_nxt  = 1'b0;
        prev_bs_nxt    = 1'b0;
        fail_nxt       = bbcs_pkg::FAIL_NONE;
      end else begin
        depth_nxt      = s_depth;
        saw_open_nxt   = s_saw_open;
        in_quote_nxt   = s_in_quote;
        in_line_nxt    = s_in_line;
        in_block_nxt   = s_in_block;
        pend_slash_nxt = s_pend_slash;
        pend_star_nxt  = s_pend_star;
        prev_bs_nxt    = (b == bbcs_pkg::CH_BACKSLASH);
        fail_nxt       = s_fail;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r      <= '0;
      saw_open_r   <= 1'b0;
      in_quote_r   <= 1'b0;
      in_line_r    <= 1'b0;
      in_block_r   <= 1'b0;
      pend_slash_r <= 1'b0;
      pend_star_r  <= 1'b0;
      prev_bs_r    <= 1'b0;
      fail_r       <= bbcs_pkg::FAIL_NONE;
    end else begin
      depth_r      <= depth_nxt;
      saw_open_r   <= saw_open_nxt;
      in_quote_r   <= in_quote_nxt;
      in_line_r    <= in_line_nxt;
      in_block_r   <= in_block_nxt;
      pend_slash_r <= pend_slash_nxt;
      pend_star_r  <= pend_star_nxt;
      prev_bs_r    <= prev_bs_nxt;
      fail_r       <= fail_nxt;
    end
  end

  // Checks
  a_depth_lim: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_LIM)
    else $error("brace depth above limit");

  a_one_note: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_line_r && in_block_r))
    else $error("line and block comment both active");

  a_star_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    pend_star_r |-> in_block_r)
    else $error("pending star outside block comment");

  a_slash_plain: assert property (@(posedge clk) disable iff (!rst_n)
    pend_slash_r |-> (!in_quote_r && !in_line_r && !in_block_r))
    else $error("pending slash inside string or comment");

  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (item_take && item.last_byte) |=> (depth_r == '0 && fail_r == bbcs_pkg::FAIL_NONE
                                       && !saw_open_r && !in_quote_r))
    else $error("state not cleared after end of text");

endmodule

`default_nettype wire

// ===== rtl/bbcs_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Result register: holds one verdict until the consumer takes it
module bbcs_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              res_valid,
  output logic                   res_ready,
  input  wire bbcs_pkg::result_t res,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bbcs_pkg::result_t      out_res
);

  logic              valid_r, valid_nxt;
  bbcs_pkg::result_t res_r;

  assign res_ready = !valid_r || out_ready;
  assign valid_nxt = res_valid || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

  // Checks
  a_acc_match: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (res_r.accepted == (res_r.fail_reason == bbcs_pkg::FAIL_NONE)))
    else $error("accepted flag disagrees with reason");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (res_r.fail_reason != 3'd7))
    else $error("reason code out of range");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> valid_r)
    else $error("verdict lost on load");

endmodule

`default_nettype wire

// ===== rtl/brace_balance_comment_scanner_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Ports                    | Contents
// in_     | slave     | tvalid tready tdata tlast | text byte, last byte of text
// out_    | master    | tvalid tready tdata       | verdict, once per text
//
// A new byte is accepted every cycle unless a last byte waits for the result register.
// An input transfer reaches its verdict through the input register, then the
// result register.
// Reset is synchronous, active low, and clears the scan state and both
// registers' valid flags.
// A stalled output only holds up the input when a verdict cannot be loaded.
module brace_balance_comment_scanner_top #(
  parameter int unsigned MAX_DEPTH = bbcs_pkg::MAX_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] text_byte
  input  wire logic       in_tlast,   // last_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [0] accepted, [3:1] fail_reason, [7:4] zero
);

  bbcs_pkg::item_t   in_item, item;
  bbcs_pkg::result_t res, out_res;
  logic              item_valid, item_take, res_valid, res_ready;

  assign in_item.text_byte = in_tdata;
  assign in_item.last_byte = in_tlast;

  bbcs_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  bbcs_scan #(.MAX_DEPTH(MAX_DEPTH)) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  bbcs_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {4'b0000, out_res.fail_reason, out_res.accepted};

endmodule

`default_nettype wire
